// ===== hw/rtl/asc_pkg.sv =====
// Shared types and constants for the allowed partition split check.
// Used by every module under hw/rtl; depends on nothing else.
package asc_pkg;

  localparam int unsigned LOG2_MIN_SIZE = 2;

  // Size thresholds in luma samples, block size width
  localparam logic [7:0] TINY_SIZE    = 8'(1 << LOG2_MIN_SIZE);
  localparam logic [7:0] TINY_SIZE_X2 = 8'(2 << LOG2_MIN_SIZE);
  localparam logic [7:0] SIZE_8       = 8'd8;
  localparam logic [7:0] SIZE_16      = 8'd16;
  localparam logic [7:0] SIZE_64      = 8'd64;

  // Area thresholds, area width
  localparam logic [15:0] AREA_32     = 16'd32;
  localparam logic [15:0] AREA_64     = 16'd64;
  localparam logic [15:0] AREA_64_X2  = 16'(64 * 2);

  // Split codes
  localparam logic [2:0] SPL_NONE = 3'd0;
  localparam logic [2:0] SPL_QUAD = 3'd1;
  localparam logic [2:0] SPL_BTH  = 3'd2;
  localparam logic [2:0] SPL_BTV  = 3'd3;
  localparam logic [2:0] SPL_TTH  = 3'd4;
  localparam logic [2:0] SPL_TTV  = 3'd5;

  localparam logic [1:0] TREE_CHROMA = 2'd2;
  localparam logic [1:0] MODE_INTER  = 2'd1;
  localparam logic [1:0] MODE_INTRA  = 2'd2;

  localparam logic [1:0] TT_MIDDLE_PART = 2'd1;

  // Configuration register indexes
  localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_INTRA_PIC    = 3'd2;
  localparam logic [2:0] CFG_MTT_DEPTH    = 3'd3;
  localparam logic [2:0] CFG_BT_SIZE      = 3'd4;
  localparam logic [2:0] CFG_TT_SIZE      = 3'd5;
  localparam logic [2:0] CFG_QT_MIN       = 3'd6;

  typedef struct packed {
    logic [13:0] frame_width;
    logic [13:0] frame_height;
    logic        intra_picture;
    logic [11:0] mtt_depth_limits;
    logic [23:0] bt_size_limits;
    logic [23:0] tt_size_limits;
    logic [23:0] qt_min_limits;
  } cfg_t;

  typedef struct packed {
    logic [12:0] block_x;
    logic [12:0] block_y;
    logic [7:0]  block_width;
    logic [7:0]  block_height;
    logic [3:0]  mt_depth;
    logic [3:0]  implicit_depth;
    logic [3:0]  tree_depth;
    logic [2:0]  parent_split;
    logic [1:0]  part_position;
    logic [1:0]  tree_kind;
    logic [1:0]  parent_mode;
  } req_t;

  // After stage 1: limits picked for the slice class, edge tests, area
  typedef struct packed {
    logic [7:0]  w;
    logic [7:0]  h;
    logic [3:0]  depth;
    logic        tdepth_nz;
    logic [2:0]  last;
    logic [1:0]  part;
    logic        chroma;
    logic [1:0]  pmode;
    logic [4:0]  max_btd;
    logic [7:0]  max_bt;
    logic [7:0]  max_tt;
    logic [7:0]  min_qt;
    logic        fits_right;
    logic        fits_below;
    logic [15:0] area;
  } prep_t;

  // After stage 2: every compare the rules need
  typedef struct packed {
    logic chroma;
    logic pm_intra;
    logic pm_inter;
    logic boundary;
    logic imp_bth;
    logic imp_btv;
    logic quad_ctx_off;
    logic tt_mid;
    logic tt_mid_hor;
    logic depth_ok;
    logic w_le_qt;
    logic w_gt_bt;
    logic h_gt_bt;
    logic w_gt_tt;
    logic h_gt_tt;
    logic w_le_min;
    logic h_le_min;
    logic w_le_2min;
    logic h_le_2min;
    logic w_le_8;
    logic w_le_16;
    logic w_gt_64;
    logic h_gt_64;
    logic area_le_64;
    logic area_le_128;
    logic area_eq_32;
    logic area_eq_64;
  } flags_t;

  typedef struct packed {
    logic allow_none;
    logic allow_quad;
    logic allow_bt_hor;
    logic allow_bt_ver;
    logic allow_tt_hor;
    logic allow_tt_ver;
    logic forced_split;
  } result_t;

endpackage

// ===== hw/rtl/asc_prep.sv =====
// Stage 1: slice class limit selection, picture edge tests and block area.
// Depends on asc_pkg.
module asc_prep (
  input  logic          clk,
  input  logic          rst_n,
  input  asc_pkg::cfg_t cfg,
  input  logic          up_valid,
  output logic          up_ready,
  input  asc_pkg::req_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output asc_pkg::prep_t dn_data
);
  import asc_pkg::*;

  logic   vld_r;
  prep_t  data_r;
  prep_t  data_nxt;
  logic   chroma;
  logic [3:0] mtt_sel;
  logic [7:0] bt_sel;
  logic [7:0] tt_sel;
  logic [7:0] qt_sel;
  logic [13:0] right_edge;
  logic [13:0] bottom_edge;

  assign chroma = (up_data.tree_kind == TREE_CHROMA);

  always_comb begin
    priority if (!cfg.intra_picture) begin
      mtt_sel = cfg.mtt_depth_limits[7:4];
      bt_sel  = cfg.bt_size_limits[15:8];
      tt_sel  = cfg.tt_size_limits[15:8];
      qt_sel  = cfg.qt_min_limits[15:8];
    end else if (chroma) begin
      mtt_sel = cfg.mtt_depth_limits[11:8];
      bt_sel  = cfg.bt_size_limits[23:16];
      tt_sel  = cfg.tt_size_limits[23:16];
      qt_sel  = cfg.qt_min_limits[23:16];
    end else begin
      mtt_sel = cfg.mtt_depth_limits[3:0];
      bt_sel  = cfg.bt_size_limits[7:0];
      tt_sel  = cfg.tt_size_limits[7:0];
      qt_sel  = cfg.qt_min_limits[7:0];
    end
  end

  assign right_edge  = {1'b0, up_data.block_x} + {6'd0, up_data.block_width};
  assign bottom_edge = {1'b0, up_data.block_y} + {6'd0, up_data.block_height};

  always_comb begin
    data_nxt.w          = up_data.block_width;
    data_nxt.h          = up_data.block_height;
    data_nxt.depth      = up_data.mt_depth;
    data_nxt.tdepth_nz  = (up_data.tree_depth != 4'd0);
    data_nxt.last       = up_data.parent_split;
    data_nxt.part       = up_data.part_position;
    data_nxt.chroma     = chroma;
    data_nxt.pmode      = up_data.parent_mode;
    data_nxt.max_btd    = {1'b0, mtt_sel} + {1'b0, up_data.implicit_depth};
    data_nxt.max_bt     = bt_sel;
    data_nxt.max_tt     = tt_sel;
    data_nxt.min_qt     = qt_sel;
    data_nxt.fits_right = (cfg.frame_width >= right_edge);
    data_nxt.fits_below = (cfg.frame_height >= bottom_edge);
    data_nxt.area       = {8'd0, up_data.block_width} * {8'd0, up_data.block_height};
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

// ===== hw/rtl/asc_cmp.sv =====
// Stage 2: size, area and depth compares plus the implied boundary split.
// Depends on asc_pkg.
module asc_cmp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  asc_pkg::prep_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output asc_pkg::flags_t dn_data
);
  import asc_pkg::*;

  logic   vld_r;
  flags_t data_r;
  flags_t data_nxt;
  logic   btd_nz;

  assign btd_nz = (up_data.max_btd != 5'd0);

  always_comb begin
    data_nxt.chroma       = up_data.chroma;
    data_nxt.pm_intra     = (up_data.pmode == MODE_INTRA);
    data_nxt.pm_inter     = (up_data.pmode == MODE_INTER);
    data_nxt.boundary     = !(up_data.fits_right && up_data.fits_below);
    // implied direction only matters on a boundary block
    data_nxt.imp_bth      = up_data.fits_right && btd_nz;
    data_nxt.imp_btv      = !up_data.fits_right && up_data.fits_below && btd_nz;
    data_nxt.quad_ctx_off = up_data.tdepth_nz && (up_data.last != SPL_QUAD);
    data_nxt.tt_mid       = ((up_data.last == SPL_TTH) || (up_data.last == SPL_TTV))
                            && (up_data.part == TT_MIDDLE_PART);
    data_nxt.tt_mid_hor   = (up_data.last == SPL_TTH);
    data_nxt.depth_ok     = ({1'b0, up_data.depth} < up_data.max_btd);
    data_nxt.w_le_qt      = (up_data.w <= up_data.min_qt);
    data_nxt.w_gt_bt      = (up_data.w > up_data.max_bt);
    data_nxt.h_gt_bt      = (up_data.h > up_data.max_bt);
    data_nxt.w_gt_tt      = (up_data.w > up_data.max_tt);
    data_nxt.h_gt_tt      = (up_data.h > up_data.max_tt);
    data_nxt.w_le_min     = (up_data.w <= TINY_SIZE);
    data_nxt.h_le_min     = (up_data.h <= TINY_SIZE);
    data_nxt.w_le_2min    = (up_data.w <= TINY_SIZE_X2);
    data_nxt.h_le_2min    = (up_data.h <= TINY_SIZE_X2);
    data_nxt.w_le_8       = (up_data.w <= SIZE_8);
    data_nxt.w_le_16      = (up_data.w <= SIZE_16);
    data_nxt.w_gt_64      = (up_data.w > SIZE_64);
    data_nxt.h_gt_64      = (up_data.h > SIZE_64);
    data_nxt.area_le_64   = (up_data.area <= AREA_64);
    data_nxt.area_le_128  = (up_data.area <= AREA_64_X2);
    data_nxt.area_eq_32   = (up_data.area == AREA_32);
    data_nxt.area_eq_64   = (up_data.area == AREA_64);
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

// ===== hw/rtl/asc_decide.sv =====
// Stage 3: combines the compare flags into the split permissions; output register.
// Depends on asc_pkg.
module asc_decide (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  asc_pkg::flags_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output asc_pkg::result_t dn_data
);
  import asc_pkg::*;

  logic    vld_r;
  result_t data_r;
  result_t data_nxt;
  flags_t  f;
  logic    quad_ok;
  logic    bnd_bth;
  logic    bnd_btv;
  logic    can_btt;
  logic    bt_big;
  logic    tt_big;

  assign f = up_data;

  assign quad_ok = !f.quad_ctx_off && !f.w_le_qt && !(f.chroma && f.w_le_8);
  assign bnd_bth = f.imp_bth && !f.h_gt_bt;
  assign bnd_btv = f.imp_btv && !f.w_gt_bt && !(f.chroma && f.w_le_8);
  assign bt_big  = f.w_gt_bt || f.h_gt_bt;
  assign tt_big  = f.w_gt_tt || f.h_gt_tt;
  assign can_btt = f.depth_ok && !(f.w_le_min && f.h_le_min) && !(bt_big && tt_big);

  always_comb begin
    data_nxt = '0;
    priority if (f.chroma && f.pm_intra) begin
      data_nxt.allow_none   = 1'b1;
      data_nxt.forced_split = f.boundary;
    end else if (f.boundary) begin
      data_nxt.allow_bt_hor = bnd_bth;
      data_nxt.allow_bt_ver = bnd_btv;
      // quad stays open when nothing else is left
      data_nxt.allow_quad   = quad_ok || !(bnd_bth || bnd_btv);
      data_nxt.forced_split = 1'b1;
    end else begin
      data_nxt.allow_none = 1'b1;
      data_nxt.allow_quad = quad_ok;
      if (can_btt) begin
        // middle part of a ternary split: no binary split parallel to it
        data_nxt.allow_bt_hor = !(f.tt_mid && f.tt_mid_hor) && !bt_big && !f.h_le_min
                                && !(f.w_gt_64 && !f.h_gt_64)
                                && !(f.chroma && f.area_le_64)
                                && !(f.pm_inter && f.area_eq_32);
        data_nxt.allow_bt_ver = !(f.tt_mid && !f.tt_mid_hor) && !bt_big && !f.w_le_min
                                && !(!f.w_gt_64 && f.h_gt_64)
                                && !(f.chroma && (f.area_le_64 || f.w_le_8))
                                && !(f.pm_inter && f.area_eq_32);
        data_nxt.allow_tt_hor = !f.h_le_2min && !tt_big && !f.w_gt_64 && !f.h_gt_64
                                && !(f.chroma && f.area_le_128)
                                && !(f.pm_inter && f.area_eq_64);
        data_nxt.allow_tt_ver = !f.w_le_2min && !tt_big && !f.w_gt_64 && !f.h_gt_64
                                && !(f.chroma && (f.area_le_128 || f.w_le_16))
                                && !(f.pm_inter && f.area_eq_64);
      end
    end
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

// ===== hw/rtl/allowed_partition_split_check.sv =====
// Top level of the allowed partition split check: config registers and three stages.
// Depends on asc_pkg, asc_prep, asc_cmp and asc_decide.
//
//   port group  dir  handshake         word
//   in_*        in   in_valid/ready    block position, size, depths, split context
//   out_*       out  out_valid/ready   six split permissions and forced split
//   cfg_*       in   cfg_we            register index and data, no read-back
//
// Three register stages: a taken word passes through the prep, compare and
// decide stage registers in that order before out_valid rises; one word per
// cycle is taken and delivered while out_ready is high. Each stage register
// moves when it is empty or the next stage takes its word, so a stall on
// out_ready backs up through the stages without loss. Synchronous reset
// clears the valid bits and loads the configuration defaults.
module allowed_partition_split_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [12:0] in_block_x,
  input  logic [12:0] in_block_y,
  input  logic [7:0]  in_block_width,
  input  logic [7:0]  in_block_height,
  input  logic [3:0]  in_mt_depth,
  input  logic [3:0]  in_implicit_depth,
  input  logic [3:0]  in_tree_depth,
  input  logic [2:0]  in_parent_split,
  input  logic [1:0]  in_part_position,
  input  logic [1:0]  in_tree_kind,
  input  logic [1:0]  in_parent_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_allow_none,
  output logic        out_allow_quad,
  output logic        out_allow_bt_hor,
  output logic        out_allow_bt_ver,
  output logic        out_allow_tt_hor,
  output logic        out_allow_tt_ver,
  output logic        out_forced_split
);
  import asc_pkg::*;

  cfg_t    cfg_r;
  req_t    req;
  prep_t   s1_data;
  flags_t  s2_data;
  result_t res;
  logic    s1_valid;
  logic    s1_ready;
  logic    s2_valid;
  logic    s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width      <= 14'd1920;
      cfg_r.frame_height     <= 14'd1080;
      cfg_r.intra_picture    <= 1'b1;
      cfg_r.mtt_depth_limits <= 12'd819;
      cfg_r.bt_size_limits   <= 24'd4210752;
      cfg_r.tt_size_limits   <= 24'd4210752;
      cfg_r.qt_min_limits    <= 24'd526344;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  cfg_r.frame_width      <= cfg_data[13:0];
        CFG_FRAME_HEIGHT: cfg_r.frame_height     <= cfg_data[13:0];
        CFG_INTRA_PIC:    cfg_r.intra_picture    <= cfg_data[0];
        CFG_MTT_DEPTH:    cfg_r.mtt_depth_limits <= cfg_data[11:0];
        CFG_BT_SIZE:      cfg_r.bt_size_limits   <= cfg_data;
        CFG_TT_SIZE:      cfg_r.tt_size_limits   <= cfg_data;
        CFG_QT_MIN:       cfg_r.qt_min_limits    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    req.block_x        = in_block_x;
    req.block_y        = in_block_y;
    req.block_width    = in_block_width;
    req.block_height   = in_block_height;
    req.mt_depth       = in_mt_depth;
    req.implicit_depth = in_implicit_depth;
    req.tree_depth     = in_tree_depth;
    req.parent_split   = in_parent_split;
    req.part_position  = in_part_position;
    req.tree_kind      = in_tree_kind;
    req.parent_mode    = in_parent_mode;
  end

  asc_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (req),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  asc_cmp u_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  asc_decide u_decide (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (res)
  );

  assign out_allow_none   = res.allow_none;
  assign out_allow_quad   = res.allow_quad;
  assign out_allow_bt_hor = res.allow_bt_hor;
  assign out_allow_bt_ver = res.allow_bt_ver;
  assign out_allow_tt_hor = res.allow_tt_hor;
  assign out_allow_tt_ver = res.allow_tt_ver;
  assign out_forced_split = res.forced_split;

endmodule
